// ----- rtl/core/transfer_region_clip_group_unit_macros.svh -----
// Assertion macros for the region clip and group block.
`ifndef TRANSFER_REGION_CLIP_GROUP_UNIT_MACROS_SVH
`define TRANSFER_REGION_CLIP_GROUP_UNIT_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define TRCG_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TRCG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/trcg_pkg.sv -----
// Shared constants, types and helpers of the region clip and group block.
`default_nettype none

package trcg_pkg;

  localparam int MAX_AXES   = 4;
  localparam int AXIS_BITS  = 16;
  localparam int MAX_GROUPS = 16;
  localparam int COUNT_BITS = 16;

  localparam int PACK_W     = 64;
  localparam int RANK_W     = 3;
  localparam int GIDX_W     = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
  localparam int GUSED_W    = $clog2(MAX_GROUPS + 1);
  localparam int OUT_GIDX_W = 4;
  localparam int OUT_MEM_W  = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FILE_RANK    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ARRAY_RANK   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PLAN_RANK    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REGION_SHAPE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FILE_BOUNDS  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ARRAY_BOUNDS = 3'd5;

  typedef logic [AXIS_BITS-1:0] axis_t;

  typedef struct packed {
    axis_t ext;
    logic  zero;
    logic  shortened;
  } axis_res_t;

  typedef struct packed {
    logic [GIDX_W-1:0]     gidx;
    logic                  is_new;
    logic [COUNT_BITS-1:0] members;
    logic                  full;
    logic                  any_clipped;
  } grp_res_t;

  // one axis field; axes past MAX_AXES read as zero
  function automatic axis_t axis_get(input logic [PACK_W-1:0] packed_v,
                                     input logic [RANK_W-1:0] idx);
    axis_t res;
    res = '0;
    for (int k = 0; k < MAX_AXES; k++) begin
      if (idx == RANK_W'(k)) res = packed_v[k*AXIS_BITS +: AXIS_BITS];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/trcg_ifs.sv -----
// Valid/ready channel interfaces for region words and result words.
`default_nettype none

interface trcg_in_if import trcg_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [PACK_W-1:0] file_start;
  logic [PACK_W-1:0] array_start;
  logic              last_region;

  modport source (output valid, file_start, array_start, last_region, input ready);
  modport sink   (input valid, file_start, array_start, last_region, output ready);
endinterface

interface trcg_out_if import trcg_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  kept;
  logic [PACK_W-1:0]     clipped_shape;
  logic [OUT_GIDX_W-1:0] group_index;
  logic                  new_group;
  logic [OUT_MEM_W-1:0]  members_so_far;
  logic                  table_full;
  logic                  any_clipped;
  logic                  plan_done;

  modport source (output valid, kept, clipped_shape, group_index, new_group,
                  members_so_far, table_full, any_clipped, plan_done, input ready);
  modport sink   (input valid, kept, clipped_shape, group_index, new_group,
                  members_so_far, table_full, any_clipped, plan_done, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/trcg_axis_lane.sv -----
// One trailing-axis clip lane: min of nominal extent and room in file and array.
`default_nettype none

module trcg_axis_lane import trcg_pkg::*; (
  input  wire axis_t     nominal,
  input  wire axis_t     f_pos,
  input  wire axis_t     f_lim,
  input  wire axis_t     a_pos,
  input  wire axis_t     a_lim,
  output axis_res_t      res
);

  axis_t room_f;
  axis_t room_a;
  axis_t ext;

  always_comb begin
    room_f = (f_pos < f_lim) ? axis_t'(f_lim - f_pos) : '0;
    room_a = (a_pos < a_lim) ? axis_t'(a_lim - a_pos) : '0;
    ext    = nominal;
    if (room_f < ext) ext = room_f;
    if (room_a < ext) ext = room_a;
    res.ext       = ext;
    res.zero      = (ext == '0);
    res.shortened = (ext != nominal);
  end

endmodule

`default_nettype wire

// ----- rtl/core/trcg_group_table.sv -----
// Shape group table: per-entry compare lanes, first-hit merge, counters and fill count.
`default_nettype none

module trcg_group_table import trcg_pkg::*; (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                adv,
  input  wire                kept,
  input  wire                clip,
  input  wire                last,
  input  wire [PACK_W-1:0]   shape,
  output grp_res_t           res
);

  logic [PACK_W-1:0]     tab_r [MAX_GROUPS];
  logic [COUNT_BITS-1:0] cnt_r [MAX_GROUPS];
  logic [GUSED_W-1:0]    used_r, used_nxt;
  logic                  seen_r, seen_nxt;

  logic [MAX_GROUPS-1:0] hit;
  logic                  any_hit;
  logic [GIDX_W-1:0]     sel;
  logic                  room;
  logic [GIDX_W-1:0]     wr_idx;
  logic                  wr_tab;
  logic                  wr_cnt;
  logic [COUNT_BITS-1:0] cnt_new;

  // compare lanes, one per entry; entries past the fill count never match
  always_comb begin
    for (int g = 0; g < MAX_GROUPS; g++) begin
      hit[g] = (GUSED_W'(g) < used_r) && (tab_r[g] == shape);
    end
  end

  // merge: lowest matching entry wins
  always_comb begin
    sel     = '0;
    any_hit = 1'b0;
    for (int g = MAX_GROUPS - 1; g >= 0; g--) begin
      if (hit[g]) begin
        sel     = GIDX_W'(g);
        any_hit = 1'b1;
      end
    end
  end

  always_comb begin
    room     = (used_r < GUSED_W'(MAX_GROUPS));
    res      = '0;
    wr_tab   = 1'b0;
    wr_cnt   = 1'b0;
    wr_idx   = sel;
    cnt_new  = '0;
    used_nxt = used_r;
    seen_nxt = seen_r | clip;
    if (kept) begin
      if (any_hit) begin
        cnt_new     = (cnt_r[sel] == '1) ? cnt_r[sel] : cnt_r[sel] + 1'b1;
        wr_cnt      = 1'b1;
        res.gidx    = sel;
        res.members = cnt_new;
      end else if (room) begin
        wr_idx      = used_r[GIDX_W-1:0];
        cnt_new     = COUNT_BITS'(1);
        wr_tab      = 1'b1;
        wr_cnt      = 1'b1;
        used_nxt    = used_r + 1'b1;
        res.gidx    = wr_idx;
        res.is_new  = 1'b1;
        res.members = cnt_new;
      end else begin
        res.full = 1'b1;
      end
    end
    res.any_clipped = seen_nxt;
    if (last) begin
      used_nxt = '0;
      seen_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
      seen_r <= 1'b0;
    end else if (adv) begin
      used_r <= used_nxt;
      seen_r <= seen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && wr_tab) tab_r[wr_idx] <= shape;
    if (adv && wr_cnt) cnt_r[wr_idx] <= cnt_new;
  end

endmodule

`default_nettype wire

// ----- rtl/core/transfer_region_clip_group_unit.sv -----
// Top level of the region clip and group block.
//
// Usage: regions enter on in_ch (valid/ready), one word per region: file and
// array start offsets, 16 bits per axis, and a last-region mark. Each accepted
// word yields exactly one result word on out_ch, in order.
// Configuration (ranks, nominal shape, bounds) goes through cfg_we/cfg_idx/
// cfg_data while the block is idle; unknown indexes are ignored.
// Pipeline: the four axis clip lanes work on the offered word before the edge
// that accepts its region into the clip stage registers; the sixteen group
// compare lanes with their first-hit merge work from those registers and
// also update the table when the result word register is loaded.
// Throughput: one region per cycle unless out_ch stalls; the table updates at
// the same edge that registers the result, so the next region sees it right away.
// Reset: ranks return to 1, shape and bounds to 0, the group table is empty
// and the running clipped flag is clear. The table also empties after the
// region marked last, whose result still shows the old state.
// Stall: when out_ch.ready is low the result word holds, the clip stage
// holds behind it, and in_ch.ready drops once both are full.
`default_nettype none

`include "transfer_region_clip_group_unit_macros.svh"

module transfer_region_clip_group_unit import trcg_pkg::*; (
  input  wire                  clk,
  input  wire                  rst_n,
  trcg_in_if.sink              in_ch,
  trcg_out_if.source           out_ch,
  input  wire                  cfg_we,
  input  wire [CFG_IDX_W-1:0]  cfg_idx,
  input  wire [CFG_DATA_W-1:0] cfg_data
);

  // configuration
  logic [RANK_W-1:0] file_rank_r, array_rank_r, plan_rank_r;
  logic [PACK_W-1:0] region_shape_r, file_bounds_r, array_bounds_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      file_rank_r    <= RANK_W'(1);
      array_rank_r   <= RANK_W'(1);
      plan_rank_r    <= RANK_W'(1);
      region_shape_r <= '0;
      file_bounds_r  <= '0;
      array_bounds_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_FILE_RANK:    file_rank_r    <= cfg_data[RANK_W-1:0];
        CFG_ARRAY_RANK:   array_rank_r   <= cfg_data[RANK_W-1:0];
        CFG_PLAN_RANK:    plan_rank_r    <= cfg_data[RANK_W-1:0];
        CFG_REGION_SHAPE: region_shape_r <= cfg_data[PACK_W-1:0];
        CFG_FILE_BOUNDS:  file_bounds_r  <= cfg_data[PACK_W-1:0];
        CFG_ARRAY_BOUNDS: array_bounds_r <= cfg_data[PACK_W-1:0];
        default: ;
      endcase
    end
  end

  // effective ranks
  logic [RANK_W-1:0] fr, ar, pr, fl, al;

  always_comb begin
    fr = (file_rank_r  > RANK_W'(MAX_AXES)) ? RANK_W'(MAX_AXES) : file_rank_r;
    ar = (array_rank_r > RANK_W'(MAX_AXES)) ? RANK_W'(MAX_AXES) : array_rank_r;
    pr = (plan_rank_r  > RANK_W'(MAX_AXES)) ? RANK_W'(MAX_AXES) : plan_rank_r;
    if (pr > fr) pr = fr;
    if (pr > ar) pr = ar;
    fl = fr - pr;
    al = ar - pr;
  end

  // handshake
  logic s1_v_r, out_v_r;
  logic adv, in_fire;

  assign adv          = s1_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready  = !s1_v_r || adv;
  assign in_fire      = in_ch.valid && in_ch.ready;

  // leading-axis drop check
  logic lead_drop;

  always_comb begin
    lead_drop = 1'b0;
    for (int j = 0; j < MAX_AXES; j++) begin
      if (RANK_W'(j) < fl &&
          axis_get(in_ch.file_start, RANK_W'(j)) >= axis_get(file_bounds_r, RANK_W'(j)))
        lead_drop = 1'b1;
      if (RANK_W'(j) < al &&
          axis_get(in_ch.array_start, RANK_W'(j)) >= axis_get(array_bounds_r, RANK_W'(j)))
        lead_drop = 1'b1;
    end
  end

  // trailing-axis clip lanes
  axis_res_t lane_res [MAX_AXES];

  for (genvar a = 0; a < MAX_AXES; a++) begin : g_lane
    trcg_axis_lane u_lane (
      .nominal (region_shape_r[a*AXIS_BITS +: AXIS_BITS]),
      .f_pos   (axis_get(in_ch.file_start,  fl + RANK_W'(a))),
      .f_lim   (axis_get(file_bounds_r,     fl + RANK_W'(a))),
      .a_pos   (axis_get(in_ch.array_start, al + RANK_W'(a))),
      .a_lim   (axis_get(array_bounds_r,    al + RANK_W'(a))),
      .res     (lane_res[a])
    );
  end

  logic              c_kept, c_short;
  logic [PACK_W-1:0] c_shape;

  always_comb begin
    c_kept  = !lead_drop;
    c_short = 1'b0;
    c_shape = '0;
    for (int a = 0; a < MAX_AXES; a++) begin
      if (RANK_W'(a) < pr) begin
        if (lane_res[a].zero) c_kept = 1'b0;
        if (lane_res[a].shortened) c_short = 1'b1;
        c_shape[a*AXIS_BITS +: AXIS_BITS] = lane_res[a].ext;
      end
    end
    if (!c_kept) c_shape = '0;
  end

  // clip stage registers
  logic              s1_kept_r, s1_clip_r, s1_last_r;
  logic [PACK_W-1:0] s1_shape_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_fire) begin
      s1_v_r <= 1'b1;
    end else if (adv) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_kept_r  <= c_kept;
      s1_clip_r  <= !c_kept || c_short;
      s1_last_r  <= in_ch.last_region;
      s1_shape_r <= c_shape;
    end
  end

  // group lanes and merge
  grp_res_t grp;

  trcg_group_table u_table (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .kept  (s1_kept_r),
    .clip  (s1_clip_r),
    .last  (s1_last_r),
    .shape (s1_shape_r),
    .res   (grp)
  );

  // result word register
  logic                  out_kept_r, out_new_r, out_full_r, out_any_r, out_done_r;
  logic [PACK_W-1:0]     out_shape_r;
  logic [OUT_GIDX_W-1:0] out_gidx_r;
  logic [OUT_MEM_W-1:0]  out_mem_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_kept_r  <= s1_kept_r;
      out_shape_r <= s1_shape_r;
      out_gidx_r  <= OUT_GIDX_W'(grp.gidx);
      out_new_r   <= grp.is_new;
      out_mem_r   <= OUT_MEM_W'(grp.members);
      out_full_r  <= grp.full;
      out_any_r   <= grp.any_clipped;
      out_done_r  <= s1_last_r;
    end
  end

  assign out_ch.valid          = out_v_r;
  assign out_ch.kept           = out_kept_r;
  assign out_ch.clipped_shape  = out_shape_r;
  assign out_ch.group_index    = out_gidx_r;
  assign out_ch.new_group      = out_new_r;
  assign out_ch.members_so_far = out_mem_r;
  assign out_ch.table_full     = out_full_r;
  assign out_ch.any_clipped    = out_any_r;
  assign out_ch.plan_done      = out_done_r;

  `TRCG_ASSERT_IMPL(a_drop_sets_clip, out_v_r && !out_kept_r,
                    out_any_r && !out_new_r && out_mem_r == '0,
                    "dropped region without clipped flag or with group info")
  `TRCG_ASSERT_IMPL(a_new_is_first, out_v_r && out_new_r,
                    out_mem_r == OUT_MEM_W'(1) && !out_full_r,
                    "new group without a single member")
  `TRCG_ASSERT_IMPL(a_full_kept, out_v_r && out_full_r,
                    out_kept_r && !out_new_r && out_mem_r == '0,
                    "table overflow on a dropped region or with group info")
  `TRCG_ASSERT_NEXT(a_stage_hold, s1_v_r && !adv,
                    s1_v_r && $stable(s1_shape_r),
                    "clip stage lost a stalled word")

endmodule

`default_nettype wire
